/* rtl/kvt_pkg.sv */
package kvt_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int OP_W        = 3;
	localparam int DATA_W      = 32;

	localparam logic [OP_W-1:0] OP_LOOKUP = 3'd0;
	localparam logic [OP_W-1:0] OP_SET    = 3'd1;
	localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
	localparam logic [OP_W-1:0] OP_MAXVAL = 3'd3;
	localparam logic [OP_W-1:0] OP_MAXKEY = 3'd4;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [OP_W-1:0]          op_t;

	// request token walking down the cell chain, with its running results
	typedef struct packed {
		logic  vld;
		op_t   op;
		data_t key;
		data_t new_value;
		data_t fallback;
		logic  hit;
		data_t best;
		logic  free_seen;
		idx_t  free_idx;
	} tok_t;

	// write of a new entry into a free slot at the end of a set walk
	typedef struct packed {
		logic  en;
		idx_t  idx;
		data_t key;
		data_t value;
	} commit_t;

	typedef struct packed {
		data_t result;
		logic  hit;
		logic  status;
	} rsp_t;

endpackage

/* rtl/kvt_if.sv */
interface kvt_req_if;
	logic                           valid;
	logic                           ready;
	logic [kvt_pkg::OP_W-1:0]       operation;
	logic signed [kvt_pkg::DATA_W-1:0] key;
	logic signed [kvt_pkg::DATA_W-1:0] new_value;
	logic signed [kvt_pkg::DATA_W-1:0] fallback_value;

	modport source (output valid, operation, key, new_value, fallback_value, input ready);
	modport sink (input valid, operation, key, new_value, fallback_value, output ready);
endinterface

interface kvt_rsp_if;
	logic                              valid;
	logic                              ready;
	logic signed [kvt_pkg::DATA_W-1:0] result_value;
	logic                              hit;
	logic                              status;

	modport source (output valid, result_value, hit, status, input ready);
	modport sink (input valid, result_value, hit, status, output ready);
endinterface

/* rtl/kvt_cell.sv */
module kvt_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  kvt_pkg::idx_t    slot_idx,
	input  kvt_pkg::tok_t    tok_in,
	input  kvt_pkg::commit_t commit,
	output kvt_pkg::tok_t    tok_out
);

	logic            valid_q;
	kvt_pkg::data_t  key_q;
	kvt_pkg::data_t  value_q;
	kvt_pkg::tok_t   tok_d;
	kvt_pkg::tok_t   tok_q;
	logic            match;
	logic            wr_commit;
	logic            wr_value;
	logic            clr_valid;

	assign match     = tok_in.vld && valid_q && (key_q == tok_in.key);
	assign wr_commit = commit.en && (commit.idx == slot_idx);

	always_comb begin
		tok_d     = tok_in;
		wr_value  = 1'b0;
		clr_valid = 1'b0;
		unique case (tok_in.op)
			kvt_pkg::OP_LOOKUP: begin
				if (match) begin
					tok_d.hit  = 1'b1;
					tok_d.best = value_q;
				end
			end
			kvt_pkg::OP_SET: begin
				if (match) begin
					tok_d.hit = 1'b1;
					wr_value  = 1'b1;
				end
				if (!valid_q && !tok_in.free_seen) begin
					tok_d.free_seen = 1'b1;
					tok_d.free_idx  = slot_idx;
				end
			end
			kvt_pkg::OP_DELETE: begin
				if (match) begin
					tok_d.hit = 1'b1;
					clr_valid = 1'b1;
				end
			end
			kvt_pkg::OP_MAXVAL: begin
				if (valid_q && (!tok_in.hit || value_q > tok_in.best)) begin
					tok_d.best = value_q;
				end
				if (valid_q) begin
					tok_d.hit = 1'b1;
				end
			end
			kvt_pkg::OP_MAXKEY: begin
				if (valid_q && (!tok_in.hit || key_q > tok_in.best)) begin
					tok_d.best = key_q;
				end
				if (valid_q) begin
					tok_d.hit = 1'b1;
				end
			end
			default: begin
				tok_d = tok_in;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr_commit) begin
			valid_q <= 1'b1;
		end else if (clr_valid) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_commit) begin
			key_q   <= commit.key;
			value_q <= commit.value;
		end else if (wr_value) begin
			value_q <= tok_in.new_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	assign tok_out = tok_q;

endmodule

/* rtl/key_value_table_with_max.sv */
// a request token is registered in each cell in turn, and its result is registered in the output buffer
// a new request is accepted only after the previous token has left the chain and the skid entry is free,
//   the token walking the cell chain one cell per cycle
// a finished result waits in a two-entry output buffer while the next request runs
// reset clears all entry valid bits and the handshake state, so the table starts empty
module key_value_table_with_max (
	input  logic      clk,
	input  logic      arst_n,
	kvt_req_if.sink   req,
	kvt_rsp_if.source rsp
);

	localparam int DEPTH = kvt_pkg::TABLE_DEPTH;

	kvt_pkg::tok_t    chain [DEPTH+1];
	kvt_pkg::tok_t    last;
	kvt_pkg::commit_t commit;
	kvt_pkg::rsp_t    rsp_d;
	kvt_pkg::rsp_t    out_q;
	kvt_pkg::rsp_t    skid_q;
	logic             out_vld_q;
	logic             skid_vld_q;
	logic             busy_q;
	logic             accept;
	logic             pop;
	logic             push;
	logic [DEPTH-1:0] tok_vlds;

	assign req.ready = !busy_q && !skid_vld_q;
	assign accept    = req.valid && req.ready;

	always_comb begin
		chain[0]           = '0;
		chain[0].vld       = accept;
		chain[0].op        = req.operation;
		chain[0].key       = req.key;
		chain[0].new_value = req.new_value;
		chain[0].fallback  = req.fallback_value;
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		kvt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.slot_idx (kvt_pkg::idx_t'(i)),
			.tok_in   (chain[i]),
			.commit   (commit),
			.tok_out  (chain[i+1])
		);
	end

	assign last = chain[DEPTH];
	assign push = last.vld;

	// a set that missed claims the lowest free slot seen on the walk
	always_comb begin
		commit.en    = last.vld && (last.op == kvt_pkg::OP_SET) && !last.hit && last.free_seen;
		commit.idx   = last.free_idx;
		commit.key   = last.key;
		commit.value = last.new_value;
	end

	always_comb begin
		rsp_d = '0;
		unique case (last.op)
			kvt_pkg::OP_LOOKUP: begin
				rsp_d.result = last.hit ? last.best : last.fallback;
				rsp_d.hit    = last.hit;
			end
			kvt_pkg::OP_SET: begin
				rsp_d.hit    = last.hit;
				rsp_d.status = !last.hit && !last.free_seen;
			end
			kvt_pkg::OP_DELETE: begin
				rsp_d.hit = last.hit;
			end
			kvt_pkg::OP_MAXVAL, kvt_pkg::OP_MAXKEY: begin
				rsp_d.result = last.best;
				rsp_d.hit    = last.hit;
			end
			default: begin
				rsp_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (last.vld) begin
			busy_q <= 1'b0;
		end
	end

	assign pop = out_vld_q && rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			priority if (pop && skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= push;
			end else if (pop) begin
				out_vld_q <= push;
			end else if (!out_vld_q) begin
				out_vld_q <= push;
			end else if (push) begin
				skid_vld_q <= 1'b1;
			end else begin
				out_vld_q  <= out_vld_q;
				skid_vld_q <= skid_vld_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (pop && skid_vld_q) begin
			out_q <= skid_q;
			if (push) begin
				skid_q <= rsp_d;
			end
		end else if (pop || !out_vld_q) begin
			if (push) begin
				out_q <= rsp_d;
			end
		end else if (push) begin
			skid_q <= rsp_d;
		end else begin
			out_q  <= out_q;
			skid_q <= skid_q;
		end
	end

	assign rsp.valid        = out_vld_q;
	assign rsp.result_value = out_q.result;
	assign rsp.hit          = out_q.hit;
	assign rsp.status       = out_q.status;

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			tok_vlds[i] = chain[i+1].vld;
		end
	end

	// only one request token is ever in the chain
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(tok_vlds) <= 1)
		else $error("more than one request token in the cell chain");

	// a token leaving the chain belongs to an accepted request still in flight
	a_tok_busy: assert property (@(posedge clk) disable iff (!arst_n)
		last.vld |-> busy_q)
		else $error("token left the chain while idle");

	// a finished result always has room in the output buffer
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !skid_vld_q)
		else $error("result arrived with the output buffer full");

	// the skid entry is only used behind a waiting output entry
	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid entry valid without output entry");

endmodule
